// ----- sv/dad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dad_pkg
// Shared widths, calendar tables and control types for the date add unit.
// ----------------------------------------------------------------------------
package dad_pkg;

  localparam int CODE_W         = 27;
  localparam int ADD_W          = 22;
  localparam int REM_W          = 23;
  localparam int DIG_W          = 7;
  localparam int MON_W          = 4;
  localparam int DAY_W          = 5;
  localparam int YEAR_OUT_W     = 14;
  localparam int DAD_YEAR_LIMIT = 10000;
  localparam int RADIX          = 100;
  localparam int LEAP_DAYS      = 366;
  localparam int COMMON_DAYS    = 365;

  // Reciprocal of 100, exact for every dividend below 2^CODE_W.
  localparam int               RCP_W      = 28;
  localparam int               DIV100_SH  = 34;
  localparam logic [RCP_W-1:0] DIV100_MUL = 28'd171798692;

  localparam logic [4:0] MLEN_COMMON [13] =
    '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
  localparam logic [4:0] MLEN_LEAP [13] =
    '{5'd0, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
  localparam logic [8:0] CUM_COMMON [13] =
    '{9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
  localparam logic [8:0] CUM_LEAP [13] =
    '{9'd0, 9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335};

  typedef struct packed {
    logic load_y;
    logic load_c;
    logic inc;
  } yr_ctl_t;

  typedef struct packed {
    logic leap;
    logic at_limit;
  } yr_stat_t;

  function automatic logic [4:0] mlen(input logic leap, input logic [DIG_W-1:0] m);
    logic [4:0] len;
    len = 5'd0;
    if (m >= DIG_W'(1) && m <= DIG_W'(12)) begin
      len = leap ? MLEN_LEAP[m[3:0]] : MLEN_COMMON[m[3:0]];
    end
    return len;
  endfunction

  function automatic logic [8:0] cum_days(input logic leap, input logic [DIG_W-1:0] m);
    logic [8:0] c;
    c = 9'd0;
    if (m >= DIG_W'(1) && m <= DIG_W'(12)) begin
      c = leap ? CUM_LEAP[m[3:0]] : CUM_COMMON[m[3:0]];
    end
    return c;
  endfunction

endpackage

// ----- sv/dad_sub.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dad_sub
// Shared subtract and compare unit: difference and a >= b flag.
// ----------------------------------------------------------------------------
module dad_sub #(
  parameter int W = 8
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[W-1:0];
  assign ge   = ~full[W];

endmodule

// ----- sv/dad_year.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dad_year
// Year counter with running mod-100 and century mod-4 counts for the leap rule.
// ----------------------------------------------------------------------------
module dad_year
  import dad_pkg::*;
#(
  parameter int YEAR_LIMIT = DAD_YEAR_LIMIT,
  parameter int YW = ($clog2(YEAR_LIMIT + 1) > YEAR_OUT_W) ?
                     $clog2(YEAR_LIMIT + 1) : YEAR_OUT_W
) (
  input  logic             clk,
  input  yr_ctl_t          ctl,
  input  logic [YW-1:0]    ld_year,
  input  logic [DIG_W-1:0] ld_c100,
  input  logic [1:0]       ld_h4,
  output logic [YW-1:0]    year,
  output yr_stat_t         stat
);

  logic [YW-1:0]    y_r;
  logic [DIG_W-1:0] c100_r;
  logic [1:0]       h4_r;

  always_ff @(posedge clk) begin
    if (ctl.load_y) begin
      y_r <= ld_year;
    end else if (ctl.inc) begin
      y_r <= y_r + YW'(1);
    end
    if (ctl.load_c) begin
      c100_r <= ld_c100;
      h4_r   <= ld_h4;
    end else if (ctl.inc) begin
      if (c100_r == DIG_W'(RADIX - 1)) begin
        c100_r <= '0;
        h4_r   <= h4_r + 2'd1;
      end else begin
        c100_r <= c100_r + DIG_W'(1);
      end
    end
  end

  assign year          = y_r;
  assign stat.leap     = ((y_r[1:0] == 2'd0) && (c100_r != '0)) ||
                         ((c100_r == '0) && (h4_r == 2'd0));
  assign stat.at_limit = (y_r >= YW'(YEAR_LIMIT));

endmodule

// ----- sv/date_add_days_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_days_unit
// Adds a day count to a decimal YYYYMMDD date on the Gregorian calendar.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid in_stall in_date_code          | in
//           | in_days_to_add                          |
//   result  | out_valid out_stall out_date_ok         | out
//           | out_out_of_range out_year out_month     |
//           | out_day                                 |
//
// One item runs through the divide, check, year walk, month walk and finish
// states from accept to accept; an invalid date goes from the check straight
// to the finish. Three reciprocal multiplications by 1/100, one a cycle, split
// the code and the year; the year and month walks share one subtractor.
// in_stall is high from accept until the result is written to the output
// register; a stalled result holds while the next transfer is taken in.
// Reset is synchronous, active low, and clears the sequencer and out_valid.
// ----------------------------------------------------------------------------
module date_add_days_unit
  import dad_pkg::*;
#(
  parameter int YEAR_LIMIT = DAD_YEAR_LIMIT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CODE_W-1:0]     in_date_code,
  input  logic [ADD_W-1:0]      in_days_to_add,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_date_ok,
  output logic                  out_out_of_range,
  output logic [YEAR_OUT_W-1:0] out_year,
  output logic [MON_W-1:0]      out_month,
  output logic [DAY_W-1:0]      out_day
);

  localparam int YW = ($clog2(YEAR_LIMIT + 1) > YEAR_OUT_W) ?
                      $clog2(YEAR_LIMIT + 1) : YEAR_OUT_W;
  localparam int PROD_W = CODE_W + RCP_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_YEAR = 3'd3;
  localparam logic [2:0] S_MON  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       pass_r, pass_nxt;
  logic [CODE_W-1:0] div_r, div_nxt;
  logic [DIG_W-1:0] d_r, d_nxt;
  logic [DIG_W-1:0] m_r, m_nxt;
  logic [ADD_W-1:0] add_r, add_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic             ok_r, ok_nxt;
  logic             out_valid_r;
  logic             load_out;

  logic [PROD_W-1:0] prod;
  logic [CODE_W-1:0] quo;
  logic [CODE_W-1:0] quo_x100;
  logic [DIG_W-1:0] rr_step;
  logic [CODE_W-1:0] div_step;
  logic [REM_W-1:0] sub_a, sub_b, sub_diff;
  logic             sub_ge;
  logic [4:0]       cur_mlen;
  logic [REM_W-1:0] ylen;
  logic             date_valid;

  yr_ctl_t          yctl;
  yr_stat_t         ystat;
  logic [YW-1:0]    year;

  dad_sub #(.W(REM_W)) u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  dad_year #(.YEAR_LIMIT(YEAR_LIMIT), .YW(YW)) u_year (
    .clk     (clk),
    .ctl     (yctl),
    .ld_year (div_step[YW-1:0]),
    .ld_c100 (rr_step),
    .ld_h4   (div_step[1:0]),
    .year    (year),
    .stat    (ystat)
  );

  assign prod     = PROD_W'(div_r) * PROD_W'(DIV100_MUL);
  assign quo      = CODE_W'(prod[PROD_W-1:DIV100_SH]);
  assign quo_x100 = quo * CODE_W'(RADIX);
  assign rr_step  = DIG_W'(div_r - quo_x100);
  assign div_step = quo;
  assign cur_mlen = mlen(ystat.leap, m_r);
  assign ylen     = ystat.leap ? REM_W'(LEAP_DAYS) : REM_W'(COMMON_DAYS);
  assign date_valid = (m_r >= DIG_W'(1)) && (m_r <= DIG_W'(12)) &&
                      (d_r >= DIG_W'(1)) && (d_r <= {2'b00, cur_mlen});

  always_comb begin
    unique case (state_r)
      S_YEAR: begin
        sub_a = rem_r;
        sub_b = ylen;
      end
      default: begin
        sub_a = rem_r;
        sub_b = REM_W'(cur_mlen);
      end
    endcase
  end

  assign load_out = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt   = state_r;
    pass_nxt    = pass_r;
    div_nxt     = div_r;
    d_nxt       = d_r;
    m_nxt       = m_r;
    add_nxt     = add_r;
    rem_nxt     = rem_r;
    ok_nxt      = ok_r;
    yctl        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          div_nxt   = in_date_code;
          add_nxt   = in_days_to_add;
          pass_nxt  = 2'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        div_nxt  = div_step;
        pass_nxt = pass_r + 2'd1;
        unique case (pass_r)
          2'd0: d_nxt = rr_step;
          2'd1: begin
            m_nxt       = rr_step;
            yctl.load_y = 1'b1;
          end
          default: begin
            yctl.load_c = 1'b1;
            state_nxt   = S_CHK;
          end
        endcase
      end
      S_CHK: begin
        ok_nxt  = date_valid;
        rem_nxt = REM_W'(cum_days(ystat.leap, m_r)) + REM_W'(d_r) + REM_W'(add_r)
                  - REM_W'(1);
        m_nxt   = DIG_W'(1);
        state_nxt = date_valid ? S_YEAR : S_FIN;
      end
      S_YEAR: begin
        if (!ystat.at_limit && sub_ge) begin
          rem_nxt  = sub_diff;
          yctl.inc = 1'b1;
        end else begin
          state_nxt = S_MON;
        end
      end
      S_MON: begin
        if ((m_r < DIG_W'(12)) && sub_ge) begin
          rem_nxt = sub_diff;
          m_nxt   = m_r + DIG_W'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    d_r   <= d_nxt;
    m_r   <= m_nxt;
    add_r <= add_nxt;
    rem_r <= rem_nxt;
    ok_r  <= ok_nxt;
    if (load_out) begin
      out_date_ok      <= ok_r;
      out_out_of_range <= ok_r && ystat.at_limit;
      if (ok_r && !ystat.at_limit) begin
        out_year  <= year[YEAR_OUT_W-1:0];
        out_month <= m_r[MON_W-1:0];
        out_day   <= DAY_W'(rem_r + REM_W'(1));
      end else begin
        out_year  <= '0;
        out_month <= '0;
        out_day   <= '0;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
